// ----- sv/qss_pkg.sv -----
// Shared types and constants for the quicksort sorter.
package qss_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int VAL_W        = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last_item;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    last_out;
    } t_out;

    // State one cell shows to its neighbors.
    typedef struct packed {
        logic                    vld;
        logic                    lt;
        logic signed [VAL_W-1:0] val;
    } t_cell;

    localparam t_cell CELL_EMPTY = '{vld: 1'b0, lt: 1'b0, val: '0};

endpackage

// ----- sv/qss_cell.sv -----
// One slot of the sorting chain: inserts from the left, drains to the left.
module qss_cell
    import qss_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_ins,
    input  logic                    i_shift,
    input  logic signed [VAL_W-1:0] i_x,
    input  t_cell                   i_left,
    input  t_cell                   i_right,
    output t_cell                   o_cell
);

    logic                    r_vld;
    logic signed [VAL_W-1:0] r_val;
    logic                    n_vld;
    logic signed [VAL_W-1:0] n_val;
    logic                    w_lt;

    // empty slot counts as +inf
    assign w_lt = r_vld ? (i_x < r_val) : 1'b1;

    always_comb begin
        n_vld = r_vld;
        n_val = r_val;
        if (i_ins && w_lt) begin
            if (i_left.lt) begin
                n_vld = i_left.vld;
                n_val = i_left.val;
            end else begin
                n_vld = 1'b1;
                n_val = i_x;
            end
        end else if (i_shift) begin
            n_vld = i_right.vld;
            n_val = i_right.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_val <= n_val;
    end

    assign o_cell = '{vld: r_vld, lt: w_lt, val: r_val};

endmodule

// ----- sv/quicksort_sorter.sv -----
// Top level: value sorter built as a chain of insertion cells.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-------------------------------
//  input   | i_in_valid  | o_in_ready  | i_in_data  (value, last_item)
//  output  | o_out_valid | i_out_ready | o_out_data (sorted_value, last_out)
//
// Load: one input transaction per cycle; each value is placed in order across
// the cell chain as it arrives. Values past MAX_ELEMENTS are dropped.
// Drain: after the last item, one result per cycle leaves from the head cell
// as the chain shifts left; input is held off until the final result is taken.
// The chain makes one insertion or one shift per cycle. Reset empties the chain;
// output stalls freeze it.
module quicksort_sorter
    import qss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_ins;
    t_cell            w_cell [MAX_ELEMENTS];

    assign o_in_ready  = i_rst_n && (r_state == ST_LOAD);
    assign o_out_valid = i_rst_n && (r_state == ST_DRAIN) && w_cell[0].vld;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign w_ins       = w_in_acc && (r_count < CNT_W'(MAX_ELEMENTS));

    assign o_out_data.sorted_value = w_cell[0].val;
    assign o_out_data.last_out     = !w_cell[1].vld;

    genvar g;
    generate
        for (g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
            qss_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ins   (w_ins),
                .i_shift (w_out_acc),
                .i_x     (i_in_data.value),
                .i_left  ((g == 0) ? CELL_EMPTY : w_cell[(g == 0) ? 0 : g - 1]),
                .i_right ((g == MAX_ELEMENTS - 1) ? CELL_EMPTY
                          : w_cell[(g == MAX_ELEMENTS - 1) ? g : g + 1]),
                .o_cell  (w_cell[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            ST_LOAD: begin
                if (w_ins) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (w_in_acc && i_in_data.last_item) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_acc && o_out_data.last_out) begin
                    n_state = ST_LOAD;
                    n_count = '0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench for quicksort_sorter: random and directed sets checked against a sorted-order predictor.
`timescale 1ns / 100ps

module tb_top;
    import qss_pkg::*;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_ITEMS = 240;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 8;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    logic signed [VAL_W-1:0] pending_set[$];
    t_out                    sorted_q[$];
    int                      err_cnt   = 0;
    bit                      idle_on   = 1'b0;
    int                      hold_req  = 0;
    int                      hold_seen = 0;
    int                      rx_gap    = 0;
    int                      rx_stall  = 0;

    quicksort_sorter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Inserts the value in order; a completed set becomes the expected run.
    function automatic void collect_value(logic signed [VAL_W-1:0] v, logic lst);
        int   pos;
        t_out r;
        if (pending_set.size() < MAX_ELEMENTS) begin
            pos = 0;
            while (pos < pending_set.size() && pending_set[pos] <= v) pos++;
            pending_set.insert(pos, v);
        end
        if (lst) begin
            foreach (pending_set[k]) begin
                r.sorted_value = pending_set[k];
                r.last_out     = (k == pending_set.size() - 1);
                sorted_q.push_back(r);
            end
            pending_set.delete();
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] random_value(int mode);
        logic signed [VAL_W-1:0] v;
        case (mode)
            0: v = $urandom();
            1: v = $signed($urandom_range(7, 0)) - 3;
            default: begin
                case ($urandom_range(3, 0))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = -1;
                    default: v = 0;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_item(input logic signed [VAL_W-1:0] v, input logic lst);
        int gap;
        gap = idle_on ? $urandom_range(3, 0) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{value: v, last_item: lst};
        do @(posedge i_clk); while (!o_in_ready);
        collect_value(v, lst);
    endtask

    task automatic send_set(input logic signed [VAL_W-1:0] vals[$]);
        foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
    endtask

    task automatic send_random_set(input int n);
        int mode;
        mode = ($urandom_range(9, 0) < 6) ? 0 : $urandom_range(2, 1);
        for (int k = 0; k < n; k++) send_item(random_value(mode), k == n - 1);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic test_directed();
        idle_on = 1'b1;
        send_set('{5});
        send_set('{VAL_MAX, VAL_MIN});
        send_set('{VAL_MIN, VAL_MAX});
        send_set('{3, 3, 3});
        send_set('{-1, 0, 1, 2});
        send_set('{2, 1, 0, -1});
        send_set('{VAL_MIN, -1, 0, VAL_MAX, 1});
        send_set('{7, 7, -7, 7});
        wait_drained();
    endtask

    task automatic test_random_sets();
        int sent;
        int n;
        int r;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(3, 0) != 0);
            r = $urandom_range(99, 0);
            if (r < 70)      n = $urandom_range(8, 1);
            else if (r < 90) n = $urandom_range(32, 9);
            else if (r < 96) n = $urandom_range(MAX_ELEMENTS, 33);
            else             n = $urandom_range(MAX_ELEMENTS + 8, MAX_ELEMENTS + 1);
            send_random_set(n);
            sent += n;
        end
        wait_drained();
    endtask

    // Receiver holds off during a drain while the next set is already offered.
    task automatic test_output_stall();
        idle_on = 1'b0;
        hold_req <= hold_req + 1;
        send_random_set(48);
        send_random_set(12);
        wait_drained();
        idle_on = 1'b1;
        hold_req <= hold_req + 1;
        send_random_set(MAX_ELEMENTS + 4);
        send_random_set(3);
        wait_drained();
    endtask

    // Sender waits for every result of a set before the next one.
    task automatic test_sender_pause();
        idle_on = 1'b1;
        for (int k = 0; k < 4; k++) begin
            send_random_set($urandom_range(10, 1));
            wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                rx_stall  = LONG_HOLD;
            end
            if (o_out_valid && i_out_ready)
                rx_gap = idle_on ? $urandom_range(3, 0) : 0;
            if (rx_stall > 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sorted_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %0d last %0b",
                         $time, o_out_data.sorted_value, o_out_data.last_out);
                err_cnt++;
            end else begin
                exp_r = sorted_q.pop_front();
                if (o_out_data.sorted_value !== exp_r.sorted_value) begin
                    $display("%0t: sorted_value expected %0d, actual %0d",
                             $time, exp_r.sorted_value, o_out_data.sorted_value);
                    err_cnt++;
                end
                if (o_out_data.last_out !== exp_r.last_out) begin
                    $display("%0t: last_out expected %0b, actual %0b",
                             $time, exp_r.last_out, o_out_data.last_out);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_sets();
        test_output_stall();
        test_sender_pause();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/qss_pkg.sv
sv/qss_cell.sv
sv/quicksort_sorter.sv
sim/tb_top.sv
